[rtl/i2c_master_bit_engine_macros.svh]
// assertion macros used by the checker file
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define I2CM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2cm_pkg.sv]
package i2cm_pkg;

    // command kinds on the input side
    localparam logic [2:0] OP_IDLE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_READ_ACK  = 3'd3;
    localparam logic [2:0] OP_READ_NACK = 3'd4;
    localparam logic [2:0] OP_STOP      = 3'd5;

    // first slot of the acknowledge clock
    localparam logic [4:0] PH_ACK_LOW = 5'd16;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] phase;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       ack;
        logic [7:0] last_read;
    } eng_state_t;

    typedef struct packed {
        logic       rejected;
        logic       ack_bit;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } eng_result_t;

    localparam eng_state_t STATE_RESET = '{
        op:        OP_IDLE,
        phase:     5'd0,
        shift:     8'd0,
        scl:       1'b1,
        sda:       1'b1,
        ack:       1'b1,
        last_read: 8'd0
    };

endpackage

[rtl/i2cm_step.sv]
module i2cm_step
    import i2cm_pkg::*;
(
    input  eng_state_t  cur,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        sda_in,
    output eng_state_t  nxt,
    output eng_result_t res
);

    logic       is_cmd;
    logic       rej;
    logic       busy;
    logic       done;
    logic       scl;
    logic       sda;
    logic [2:0] op;
    logic [4:0] ph;

    always_comb
    begin
        is_cmd = (kind >= OP_START) && (kind <= OP_STOP);
        nxt    = cur;
        rej    = 1'b0;
        busy   = 1'b0;
        done   = 1'b0;
        scl    = cur.scl;
        sda    = cur.sda;

        // take a new command only while idle
        if (cur.op == OP_IDLE)
        begin
            if (is_cmd)
            begin
                nxt.op    = kind;
                nxt.phase = 5'd0;
                nxt.shift = (kind == OP_WRITE) ? data_byte : 8'd0;
            end
        end
        else if (is_cmd)
        begin
            rej = 1'b1;
        end

        op = nxt.op;
        ph = nxt.phase;

        if (op != OP_IDLE)
        begin
            busy = 1'b1;
            unique case (op)
                OP_START:
                begin
                    scl  = 1'b1;
                    sda  = (ph == 5'd0);
                    done = (ph != 5'd0);
                end
                OP_WRITE:
                begin
                    if (!ph[4])
                    begin
                        scl = ph[0];
                        sda = nxt.shift[7];
                        if (ph[0])
                            nxt.shift = {nxt.shift[6:0], 1'b0};
                    end
                    else
                    begin
                        sda = 1'b1;
                        scl = (ph != PH_ACK_LOW);
                        if (ph != PH_ACK_LOW)
                        begin
                            nxt.ack = sda_in;
                            done    = 1'b1;
                        end
                    end
                end
                OP_READ_ACK, OP_READ_NACK:
                begin
                    if (!ph[4])
                    begin
                        scl = ph[0];
                        sda = 1'b1;
                        if (ph[0])
                            nxt.shift = {nxt.shift[6:0], sda_in};
                    end
                    else
                    begin
                        sda = (op == OP_READ_NACK);
                        scl = (ph != PH_ACK_LOW);
                        if (ph != PH_ACK_LOW)
                        begin
                            nxt.last_read = nxt.shift;
                            done          = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // stop: low/low, high/low, then release both
                    if (ph == 5'd0)
                    begin
                        scl = 1'b0;
                        sda = 1'b0;
                    end
                    else if (ph == 5'd1)
                    begin
                        scl = 1'b1;
                        sda = 1'b0;
                    end
                    else
                    begin
                        scl  = 1'b1;
                        sda  = 1'b1;
                        done = 1'b1;
                    end
                end
            endcase

            if (done)
            begin
                nxt.scl   = (op == OP_STOP);
                nxt.sda   = sda;
                nxt.op    = OP_IDLE;
                nxt.phase = 5'd0;
            end
            else
            begin
                nxt.scl   = scl;
                nxt.sda   = sda;
                nxt.phase = ph + 5'd1;
            end
        end

        res.scl_out   = scl;
        res.sda_out   = sda;
        res.busy_res  = busy;
        res.done_res  = done;
        res.read_byte = nxt.last_read;
        res.ack_bit   = nxt.ack;
        res.rejected  = rej;
    end

endmodule

[rtl/i2c_master_bit_engine.sv]
// I2C master bit engine: every input transfer is one timing slot of the bus and
// produces exactly one output transfer with the SCL/SDA levels to drive in that
// slot plus busy, done, last read byte, last sampled ack and a rejected flag.
// Commands (start, write, read with ack, read with nack, stop) are taken only
// while idle; a command arriving mid-sequence is dropped and flagged rejected.
// Throughput is one slot per clock while the output accepts: a slot is captured in
// the input register, stepped through the phase logic and lands in the output
// register. The output
// register frees the input side while a result waits; backpressure on the
// output stalls the input stage. No clock stretching, no arbitration.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0], sda_in[8], zero pad
    input  logic [2:0]            s_tuser,   // kind[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // scl_out[0], sda_out[1], busy_res[2],
                                             // done_res[3], read_byte[11:4],
                                             // ack_bit[12], rejected[13], zero pad
);

    // input stage
    logic        in_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  data_byte_reg;
    logic        sda_in_reg;

    // engine state and output stage
    eng_state_t  state_reg;
    eng_state_t  state_next;
    eng_result_t res_next;
    eng_result_t out_reg;
    logic        out_valid_reg;

    logic        advance;

    // the slot in the input stage moves on when the output slot is free or leaving
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    i2cm_step u_step (
        .cur       (state_reg),
        .kind      (kind_reg),
        .data_byte (data_byte_reg),
        .sda_in    (sda_in_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg      <= s_tuser;
            data_byte_reg <= s_tdata[7:0];
            sda_in_reg    <= s_tdata[8];
        end
        if (advance)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 14){1'b0}}, out_reg};

endmodule

[rtl/i2cm_checker.sv]
`include "i2c_master_bit_engine_macros.svh"

module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a rejected command only happens during a running sequence
    `I2CM_ASSERT_SAME(a_rej_busy, clk, rst_n,
        m_tvalid && m_tdata[13], m_tdata[2], "rejected while idle")

    // a finishing slot belongs to a sequence
    `I2CM_ASSERT_SAME(a_done_busy, clk, rst_n,
        m_tvalid && m_tdata[3], m_tdata[2], "done while idle")

    // an idle result followed by another idle result shows the same line levels
    `I2CM_ASSERT_NEXT(a_idle_hold, clk, rst_n,
        m_tvalid && m_tready && !m_tdata[2] && !m_tdata[3],
        !m_tvalid || m_tdata[2] || (m_tdata[1:0] == $past(m_tdata[1:0])) || $past(m_tdata[3]),
        "idle line levels changed")

    // a stalled result holds
    `I2CM_ASSERT_NEXT(a_out_hold, clk, rst_n,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
